[hdl/ton_pkg.sv]
// Shared constants, types and byte tables of the telnet option negotiator.
package ton_pkg;

    localparam logic [7:0] SUBNEG_SKIP_LIMIT = 8'd128;
    localparam int         QUEUE_DEPTH       = 4;
    localparam int         QUEUE_AW          = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_AYT  = 8'd246;
    localparam logic [7:0] B_NOP  = 8'd241;

    localparam logic [7:0] OPT_BINARY = 8'd0;
    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_SGA    = 8'd3;

    localparam logic [1:0] SLOT_BINARY = 2'd0;
    localparam logic [1:0] SLOT_ECHO   = 2'd1;
    localparam logic [1:0] SLOT_SGA    = 2'd2;

    localparam logic [1:0] CMD_RX    = 2'd0;
    localparam logic [1:0] CMD_USER  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [2:0] ST_DATA  = 3'd0;
    localparam logic [2:0] ST_IAC   = 3'd1;
    localparam logic [2:0] ST_WILL  = 3'd2;
    localparam logic [2:0] ST_WONT  = 3'd3;
    localparam logic [2:0] ST_DO    = 3'd4;
    localparam logic [2:0] ST_DONT  = 3'd5;
    localparam logic [2:0] ST_SB    = 3'd6;
    localparam logic [2:0] ST_SBIAC = 3'd7;

    localparam logic [2:0] KIND_TERM  = 3'd0;
    localparam logic [2:0] KIND_SRV1  = 3'd1;
    localparam logic [2:0] KIND_SRV2  = 3'd2;
    localparam logic [2:0] KIND_AYT   = 3'd3;
    localparam logic [2:0] KIND_REPLY = 3'd4;
    localparam logic [2:0] KIND_START = 3'd5;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] verb;
        logic [7:0] data;
    } job_t;

    function automatic logic opt_known(input logic [7:0] opt);
        return (opt == OPT_BINARY) || (opt == OPT_ECHO) || (opt == OPT_SGA);
    endfunction

    function automatic logic [1:0] opt_slot(input logic [7:0] opt);
        logic [1:0] slot;
        case (opt)
            OPT_ECHO: slot = SLOT_ECHO;
            OPT_SGA:  slot = SLOT_SGA;
            default:  slot = SLOT_BINARY;
        endcase
        return slot;
    endfunction

    function automatic logic [3:0] job_len(input logic [2:0] kind);
        logic [3:0] len;
        case (kind)
            KIND_SRV2:  len = 4'd2;
            KIND_AYT:   len = 4'd2;
            KIND_REPLY: len = 4'd3;
            KIND_START: len = 4'd9;
            default:    len = 4'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] job_byte(input job_t job, input logic [3:0] idx);
        logic [7:0] b;
        b = job.data;
        case (job.kind)
            KIND_AYT: begin
                b = (idx == 4'd0) ? B_IAC : B_NOP;
            end
            KIND_REPLY: begin
                case (idx)
                    4'd0:    b = B_IAC;
                    4'd1:    b = job.verb;
                    default: b = job.data;
                endcase
            end
            KIND_START: begin
                case (idx)
                    4'd1, 4'd4: b = B_WILL;
                    4'd7:       b = B_DO;
                    4'd2:       b = OPT_ECHO;
                    4'd5, 4'd8: b = OPT_SGA;
                    default:    b = B_IAC;
                endcase
            end
            default: b = job.data;
        endcase
        return b;
    endfunction

endpackage

[hdl/ton_front.sv]
// Front end: telnet parser, option maps and job classification.
module ton_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  logic [1:0]     cmd,
    input  logic [7:0]     data_byte,
    output logic           push,
    output ton_pkg::job_t  job
);

    logic [2:0] state_reg, state_next;
    logic [7:0] skip_reg, skip_next;
    logic [7:0] skip_inc;
    logic [2:0] loc_reg, loc_next;
    logic [2:0] rem_reg, rem_next;
    logic [1:0] slot;
    logic       known;
    logic       loc_on;
    logic       rem_on;

    assign slot     = ton_pkg::opt_slot(data_byte);
    assign known    = ton_pkg::opt_known(data_byte);
    assign loc_on   = known && loc_reg[slot];
    assign rem_on   = known && rem_reg[slot];
    assign skip_inc = skip_reg + 8'd1;

    always_comb begin
        state_next = state_reg;
        skip_next  = skip_reg;
        loc_next   = loc_reg;
        rem_next   = rem_reg;
        push       = 1'b0;
        job.kind   = ton_pkg::KIND_TERM;
        job.verb   = ton_pkg::B_NOP;
        job.data   = data_byte;
        if (accept) begin
            case (cmd)
                ton_pkg::CMD_RX: begin
                    case (state_reg)
                        ton_pkg::ST_DATA: begin
                            if (data_byte == ton_pkg::B_IAC) begin
                                state_next = ton_pkg::ST_IAC;
                            end else begin
                                push = 1'b1;
                            end
                        end
                        ton_pkg::ST_IAC: begin
                            state_next = ton_pkg::ST_DATA;
                            case (data_byte)
                                ton_pkg::B_IAC:  push = 1'b1;
                                ton_pkg::B_AYT: begin
                                    push     = 1'b1;
                                    job.kind = ton_pkg::KIND_AYT;
                                end
                                ton_pkg::B_WILL: state_next = ton_pkg::ST_WILL;
                                ton_pkg::B_WONT: state_next = ton_pkg::ST_WONT;
                                ton_pkg::B_DO:   state_next = ton_pkg::ST_DO;
                                ton_pkg::B_DONT: state_next = ton_pkg::ST_DONT;
                                ton_pkg::B_SB: begin
                                    state_next = ton_pkg::ST_SB;
                                    skip_next  = 8'd0;
                                end
                                default: state_next = ton_pkg::ST_DATA;
                            endcase
                        end
                        ton_pkg::ST_WILL: begin
                            state_next = ton_pkg::ST_DATA;
                            if (!rem_on) begin
                                push     = 1'b1;
                                job.kind = ton_pkg::KIND_REPLY;
                                if (known) begin
                                    rem_next[slot] = 1'b1;
                                    job.verb       = ton_pkg::B_DO;
                                end else begin
                                    job.verb = ton_pkg::B_DONT;
                                end
                            end
                        end
                        ton_pkg::ST_WONT: begin
                            state_next = ton_pkg::ST_DATA;
                            if (rem_on) begin
                                push           = 1'b1;
                                job.kind       = ton_pkg::KIND_REPLY;
                                job.verb       = ton_pkg::B_DONT;
                                rem_next[slot] = 1'b0;
                            end
                        end
                        ton_pkg::ST_DO: begin
                            state_next = ton_pkg::ST_DATA;
                            if (!loc_on) begin
                                push     = 1'b1;
                                job.kind = ton_pkg::KIND_REPLY;
                                if (known) begin
                                    loc_next[slot] = 1'b1;
                                    job.verb       = ton_pkg::B_WILL;
                                end else begin
                                    job.verb = ton_pkg::B_WONT;
                                end
                            end
                        end
                        ton_pkg::ST_DONT: begin
                            state_next = ton_pkg::ST_DATA;
                            if (loc_on) begin
                                push           = 1'b1;
                                job.kind       = ton_pkg::KIND_REPLY;
                                job.verb       = ton_pkg::B_WONT;
                                loc_next[slot] = 1'b0;
                            end
                        end
                        ton_pkg::ST_SB: begin
                            if (data_byte == ton_pkg::B_IAC) begin
                                state_next = ton_pkg::ST_SBIAC;
                            end else begin
                                skip_next = skip_inc;
                                if (skip_inc >= ton_pkg::SUBNEG_SKIP_LIMIT) begin
                                    state_next = ton_pkg::ST_DATA;
                                end
                            end
                        end
                        default: state_next = ton_pkg::ST_DATA;
                    endcase
                end
                ton_pkg::CMD_USER: begin
                    push     = 1'b1;
                    job.kind = (data_byte == ton_pkg::B_IAC) ? ton_pkg::KIND_SRV2
                                                             : ton_pkg::KIND_SRV1;
                end
                ton_pkg::CMD_START: begin
                    push                       = 1'b1;
                    job.kind                   = ton_pkg::KIND_START;
                    loc_next[ton_pkg::SLOT_ECHO] = 1'b1;
                    loc_next[ton_pkg::SLOT_SGA]  = 1'b1;
                    rem_next[ton_pkg::SLOT_SGA]  = 1'b1;
                end
                default: push = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ton_pkg::ST_DATA;
            skip_reg  <= 8'd0;
            loc_reg   <= 3'd0;
            rem_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            skip_reg  <= skip_next;
            loc_reg   <= loc_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

[hdl/ton_queue.sv]
// Job queue between the parser front end and the byte sender.
module ton_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ton_pkg::job_t  push_job,
    output logic           in_ready,
    output logic           job_valid,
    output ton_pkg::job_t  job,
    input  logic           pop
);

    localparam int AW = ton_pkg::QUEUE_AW;

    ton_pkg::job_t mem_reg [ton_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    assign in_ready  = (count_reg != (AW+1)'(ton_pkg::QUEUE_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/ton_back.sv]
// Back end: expands queued jobs into output bytes, one per cycle while m_ready is high.
module ton_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           job_valid,
    input  ton_pkg::job_t  job,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_to_server,
    output logic           m_last
);

    logic       load;
    logic       at_end;
    logic [3:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       srv_reg;
    logic       last_reg;

    assign load   = job_valid && (!valid_reg || m_ready);
    assign at_end = (idx_reg == (ton_pkg::job_len(job.kind) - 4'd1));
    assign pop    = load && at_end;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = at_end ? 4'd0 : idx_reg + 4'd1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= ton_pkg::job_byte(job, idx_reg);
            srv_reg  <= (job.kind != ton_pkg::KIND_TERM);
            last_reg <= at_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid     = valid_reg;
    assign m_out_byte  = byte_reg;
    assign m_to_server = srv_reg;
    assign m_last      = last_reg;

endmodule

[hdl/telnet_option_negotiator.sv]
// Top level of the telnet option negotiator: parser, job queue and byte sender.
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_cmd, s_data_byte
//  m_        out        m_valid / m_ready   m_out_byte, m_to_server, m_last
//
// One input item is accepted per cycle while the four-entry job queue has room.
// The sender emits one byte per cycle while m_ready is high: one or two for data, two
// for AYT, three for an option reply, nine for a start command; that byte rate sets
// throughput. Input passes the job queue and output register. Reset is synchronous,
// active low, and clears parser state, both option maps, the queue and the output
// register. Either side may stall independently; the queue absorbs the difference.
module telnet_option_negotiator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_to_server,
    output logic       m_last
);

    logic          accept;
    logic          push;
    ton_pkg::job_t push_job;
    logic          job_valid;
    ton_pkg::job_t job;
    logic          pop;

    assign accept = s_valid && s_ready;

    ton_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .cmd       (s_cmd),
        .data_byte (s_data_byte),
        .push      (push),
        .job       (push_job)
    );

    ton_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .in_ready  (s_ready),
        .job_valid (job_valid),
        .job       (job),
        .pop       (pop)
    );

    ton_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (job_valid),
        .job         (job),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_to_server (m_to_server),
        .m_last      (m_last)
    );

    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (s_valid && s_ready))
        else $error("job pushed without an accepted item");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> job_valid)
        else $error("job popped from empty queue");

    a_start_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_cmd == ton_pkg::CMD_START)) |=> job_valid)
        else $error("start item left no queued job");

    a_pop_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_valid && m_last))
        else $error("job retired without a last byte");

endmodule

[verif/ton_checker.sv]
// Checker for the telnet option negotiator: predicts emitted bytes and compares them.
module ton_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_data_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_to_server,
    input  logic       m_last,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [7:0] value;
        logic       to_srv;
        logic       last;
    } tx_byte_t;

    tx_byte_t   owed_bytes[$];
    tx_byte_t   step_out[$];
    logic [2:0] rx_state;
    logic [7:0] sb_skipped;
    bit         local_on[256];
    bit         remote_on[256];
    int         errors = 0;

    function automatic bit option_ok(input logic [7:0] opt);
        return (opt == ton_pkg::OPT_BINARY) || (opt == ton_pkg::OPT_ECHO) ||
               (opt == ton_pkg::OPT_SGA);
    endfunction

    task emit(input logic [7:0] v, input logic srv);
        tx_byte_t e;
        e.value  = v;
        e.to_srv = srv;
        e.last   = 1'b0;
        step_out.push_back(e);
    endtask

    task reply(input logic [7:0] verb, input logic [7:0] opt);
        emit(ton_pkg::B_IAC, 1'b1);
        emit(verb, 1'b1);
        emit(opt, 1'b1);
    endtask

    task peer_will(input logic [7:0] opt);
        if (option_ok(opt)) begin
            remote_on[opt] = 1'b1;
            reply(ton_pkg::B_DO, opt);
        end else begin
            reply(ton_pkg::B_DONT, opt);
        end
    endtask

    task peer_wont(input logic [7:0] opt);
        if (option_ok(opt))
            remote_on[opt] = 1'b0;
        reply(ton_pkg::B_DONT, opt);
    endtask

    task peer_do(input logic [7:0] opt);
        if (option_ok(opt)) begin
            local_on[opt] = 1'b1;
            reply(ton_pkg::B_WILL, opt);
        end else begin
            reply(ton_pkg::B_WONT, opt);
        end
    endtask

    task peer_dont(input logic [7:0] opt);
        if (option_ok(opt))
            local_on[opt] = 1'b0;
        reply(ton_pkg::B_WONT, opt);
    endtask

    task parse_rx(input logic [7:0] b);
        case (rx_state)
            ton_pkg::ST_DATA: begin
                if (b == ton_pkg::B_IAC)
                    rx_state = ton_pkg::ST_IAC;
                else
                    emit(b, 1'b0);
            end
            ton_pkg::ST_IAC: begin
                rx_state = ton_pkg::ST_DATA;
                case (b)
                    ton_pkg::B_IAC: emit(ton_pkg::B_IAC, 1'b0);
                    ton_pkg::B_AYT: begin
                        emit(ton_pkg::B_IAC, 1'b1);
                        emit(ton_pkg::B_NOP, 1'b1);
                    end
                    ton_pkg::B_WILL: rx_state = ton_pkg::ST_WILL;
                    ton_pkg::B_WONT: rx_state = ton_pkg::ST_WONT;
                    ton_pkg::B_DO:   rx_state = ton_pkg::ST_DO;
                    ton_pkg::B_DONT: rx_state = ton_pkg::ST_DONT;
                    ton_pkg::B_SB: begin
                        rx_state   = ton_pkg::ST_SB;
                        sb_skipped = 8'd0;
                    end
                    default: ;
                endcase
            end
            ton_pkg::ST_WILL: begin
                rx_state = ton_pkg::ST_DATA;
                if (!remote_on[b])
                    peer_will(b);
            end
            ton_pkg::ST_WONT: begin
                rx_state = ton_pkg::ST_DATA;
                if (remote_on[b])
                    peer_wont(b);
            end
            ton_pkg::ST_DO: begin
                rx_state = ton_pkg::ST_DATA;
                if (!local_on[b])
                    peer_do(b);
            end
            ton_pkg::ST_DONT: begin
                rx_state = ton_pkg::ST_DATA;
                if (local_on[b])
                    peer_dont(b);
            end
            ton_pkg::ST_SB: begin
                if (b == ton_pkg::B_IAC) begin
                    rx_state = ton_pkg::ST_SBIAC;
                end else begin
                    sb_skipped = sb_skipped + 8'd1;
                    if (sb_skipped >= ton_pkg::SUBNEG_SKIP_LIMIT)
                        rx_state = ton_pkg::ST_DATA;
                end
            end
            default: rx_state = ton_pkg::ST_DATA;
        endcase
    endtask

    task predict_event(input logic [1:0] cmd, input logic [7:0] b);
        tx_byte_t e;
        step_out.delete();
        case (cmd)
            ton_pkg::CMD_RX: parse_rx(b);
            ton_pkg::CMD_USER: begin
                emit(b, 1'b1);
                if (b == ton_pkg::B_IAC)
                    emit(b, 1'b1);
            end
            ton_pkg::CMD_START: begin
                peer_do(ton_pkg::OPT_ECHO);
                peer_do(ton_pkg::OPT_SGA);
                peer_will(ton_pkg::OPT_SGA);
            end
            default: ;
        endcase
        for (int i = 0; i < step_out.size(); i++) begin
            e      = step_out[i];
            e.last = (i == step_out.size() - 1);
            owed_bytes.push_back(e);
        end
    endtask

    always @(posedge aclk) begin
        tx_byte_t want;
        if (!aresetn) begin
            rx_state   = ton_pkg::ST_DATA;
            sb_skipped = 8'd0;
            for (int i = 0; i < 256; i++) begin
                local_on[i]  = 1'b0;
                remote_on[i] = 1'b0;
            end
            owed_bytes.delete();
        end else begin
            if (s_valid && s_ready)
                predict_event(s_cmd, s_data_byte);
            if (m_valid && m_ready) begin
                if (owed_bytes.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected byte: out_byte %0d to_server %0b last %0b",
                                 m_out_byte, m_to_server, m_last);
                end else begin
                    want = owed_bytes.pop_front();
                    if (m_out_byte !== want.value || m_to_server !== want.to_srv ||
                        m_last !== want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     want.value, want.to_srv, want.last,
                                     m_out_byte, m_to_server, m_last);
                    end
                end
            end
        end
        fail_count <= errors;
        pending    <= owed_bytes.size();
    end

endmodule

[verif/tb_top.sv]
// Testbench top for the telnet option negotiator: stimulus, flow control and verdict.
module tb_top;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         LONG_HOLD    = 80;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         RAND_EVENTS  = 24;
    localparam int         RUN_LIMIT    = 1600000;

    localparam int RX_FREE    = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [1:0] s_cmd       = ton_pkg::CMD_RX;
    logic [7:0] s_data_byte = 8'd0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_to_server;
    logic       m_last;

    int fail_count;
    int pending;
    int squeeze_req = 0;
    int burst_left  = 0;
    bit gaps_off    = 1'b0;
    int events_sent = 0;

    telnet_option_negotiator u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_to_server (m_to_server),
        .m_last      (m_last)
    );

    ton_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_to_server (m_to_server),
        .m_last      (m_last),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    task automatic offer(input logic [1:0] c, input logic [7:0] d);
        int gap;
        s_valid     <= 1'b1;
        s_cmd       <= c;
        s_data_byte <= d;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (c != CMD_UNUSED)
            events_sent++;
        if (!gaps_off) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
                repeat (gap) @(posedge aclk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic rx_option(input logic [7:0] verb, input logic [7:0] opt);
        offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
        offer(ton_pkg::CMD_RX, verb);
        offer(ton_pkg::CMD_RX, opt);
    endtask

    task automatic wait_all_out();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    function automatic logic [7:0] any_verb();
        case ($urandom_range(0, 3))
            0:       return ton_pkg::B_WILL;
            1:       return ton_pkg::B_WONT;
            2:       return ton_pkg::B_DO;
            default: return ton_pkg::B_DONT;
        endcase
    endfunction

    function automatic logic [7:0] any_option();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 2))
            0:       return ton_pkg::OPT_BINARY;
            1:       return ton_pkg::OPT_ECHO;
            default: return ton_pkg::OPT_SGA;
        endcase
    endfunction

    task automatic random_sequence();
        int         pick;
        int         n;
        logic [7:0] b;
        logic [7:0] verb;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            offer(ton_pkg::CMD_RX, 8'($urandom_range(0, 254)));
        end else if (pick < 45) begin
            rx_option(any_verb(), any_option());
        end else if (pick < 52) begin
            offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
            offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
        end else if (pick < 58) begin
            offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
            offer(ton_pkg::CMD_RX, ton_pkg::B_AYT);
        end else if (pick < 64) begin
            offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
            offer(ton_pkg::CMD_RX, ton_pkg::B_SB);
            n = $urandom_range(0, 6);
            repeat (n) offer(ton_pkg::CMD_RX, 8'($urandom_range(0, 254)));
            offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
            offer(ton_pkg::CMD_RX, 8'($urandom_range(0, 255)));
        end else if (pick < 68) begin
            b = 8'($urandom_range(0, 255));
            if (b == ton_pkg::B_IAC || b == ton_pkg::B_AYT || b == ton_pkg::B_SB ||
                b >= ton_pkg::B_WILL)
                b = ton_pkg::B_NOP;
            offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
            offer(ton_pkg::CMD_RX, b);
        end else if (pick < 80) begin
            b = ($urandom_range(0, 3) == 0) ? ton_pkg::B_IAC : 8'($urandom_range(0, 255));
            offer(ton_pkg::CMD_USER, b);
        end else if (pick < 85) begin
            offer(ton_pkg::CMD_START, 8'($urandom_range(0, 255)));
        end else if (pick < 92) begin
            offer(ton_pkg::CMD_RX, 8'($urandom_range(0, 255)));
        end else if (pick < 97) begin
            verb = any_verb();
            offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
            if ($urandom_range(0, 1) == 0)
                offer(ton_pkg::CMD_USER, 8'($urandom_range(0, 255)));
            offer(ton_pkg::CMD_RX, verb);
            if ($urandom_range(0, 1) == 0)
                offer(ton_pkg::CMD_START, 8'($urandom_range(0, 255)));
            offer(ton_pkg::CMD_RX, any_option());
        end else begin
            offer(CMD_UNUSED, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic long_subneg(input bit end_by_iac);
        offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
        offer(ton_pkg::CMD_RX, ton_pkg::B_SB);
        repeat (end_by_iac ? ton_pkg::SUBNEG_SKIP_LIMIT - 1 : ton_pkg::SUBNEG_SKIP_LIMIT)
            offer(ton_pkg::CMD_RX, 8'($urandom_range(0, 254)));
        if (end_by_iac) begin
            offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
            offer(ton_pkg::CMD_RX, 8'hF0);
        end
        offer(ton_pkg::CMD_RX, end_by_iac ? 8'hAA : 8'h55);
    endtask

    initial begin : rx_side
        int         seen;
        int         span;
        int         mode;
        logic [7:0] pat;
        seen = 0;
        span = 0;
        mode = RX_FREE;
        pat  = 8'hB6;
        forever begin
            @(posedge aclk);
            if (squeeze_req != seen) begin
                seen = squeeze_req;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (span == 0) begin
                mode = $urandom_range(RX_FREE, RX_PATTERN);
                span = $urandom_range(16, 64);
                pat  = 8'($urandom_range(1, 255));
            end
            span--;
            case (mode)
                RX_FREE:   m_ready <= 1'b1;
                RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    m_ready <= pat[0];
                    pat = {pat[0], pat[7:1]};
                end
            endcase
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer(ton_pkg::CMD_START, 8'hA5);
        offer(ton_pkg::CMD_RX, 8'h00);
        offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
        offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
        offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
        offer(ton_pkg::CMD_RX, ton_pkg::B_AYT);
        offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
        offer(ton_pkg::CMD_RX, ton_pkg::B_WILL);
        offer(ton_pkg::CMD_USER, 8'h41);
        offer(ton_pkg::CMD_RX, ton_pkg::OPT_ECHO);
        rx_option(ton_pkg::B_DO, 8'hFF);
        rx_option(ton_pkg::B_DONT, ton_pkg::OPT_ECHO);
        rx_option(ton_pkg::B_WONT, ton_pkg::OPT_SGA);
        offer(ton_pkg::CMD_USER, ton_pkg::B_IAC);
        offer(ton_pkg::CMD_USER, 8'h00);
        offer(CMD_UNUSED, 8'h00);
        offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
        offer(ton_pkg::CMD_RX, 8'h10);
        offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
        offer(ton_pkg::CMD_RX, ton_pkg::B_SB);
        offer(ton_pkg::CMD_RX, 8'h18);
        offer(ton_pkg::CMD_RX, ton_pkg::B_IAC);
        offer(ton_pkg::CMD_RX, 8'hF0);

        events_sent = 0;
        while (events_sent < RAND_EVENTS / 2)
            random_sequence();

        // hold the receiver off while items keep coming
        wait_all_out();
        gaps_off = 1'b1;
        squeeze_req <= squeeze_req + 1;
        repeat (12) begin
            if ($urandom_range(0, 1) == 0)
                offer(ton_pkg::CMD_START, 8'($urandom_range(0, 255)));
            else
                offer(ton_pkg::CMD_USER, 8'($urandom_range(0, 255)));
        end
        gaps_off = 1'b0;
        wait_all_out();

        while (events_sent < RAND_EVENTS)
            random_sequence();

        long_subneg(1'b0);

        wait_all_out();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[sim.f]
hdl/ton_pkg.sv
hdl/ton_front.sv
hdl/ton_queue.sv
hdl/ton_back.sv
hdl/telnet_option_negotiator.sv
verif/ton_checker.sv
verif/tb_top.sv
